/* hdl/dtts_pkg.sv */
// ----------------------------------------------------------------------------
// dtts_pkg
// Types and constants shared by the duration text to seconds block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtts_pkg;

  // One character of the duration text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  // One parsed duration.
  typedef struct packed {
    logic [31:0] total_seconds;
    logic        bad_format;
  } out_item_t;

  // Class of a character as decided by the front end.
  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_UNIT,
    OP_BAD
  } op_kind_t;

  localparam int MULT_W = 17;

  // Classified character as queued between front and back.
  typedef struct packed {
    op_kind_t            kind;
    logic [3:0]          digit;
    logic [MULT_W-1:0]   mult;
    logic                last;
  } op_t;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DAY  = 8'h64;
  localparam logic [7:0] CHAR_HOUR = 8'h68;
  localparam logic [7:0] CHAR_MIN  = 8'h6d;
  localparam logic [7:0] CHAR_SEC  = 8'h73;

  localparam logic [MULT_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [MULT_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [MULT_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [MULT_W-1:0] SECS_PER_SEC  = 17'd1;

endpackage

`default_nettype wire

/* hdl/dtts_front.sv */
// ----------------------------------------------------------------------------
// dtts_front
// Accepts characters and classifies them into digit, unit or bad operations.
// ----------------------------------------------------------------------------
`default_nettype none

module dtts_front (
  input  wire               item_valid,
  input  dtts_pkg::in_item_t item,
  output logic              item_stall,
  input  wire               queue_full,
  output logic              push,
  output dtts_pkg::op_t     push_op
);

  logic [7:0] ch;
  logic [3:0] digit_value;

  assign ch          = item.char_code;
  assign digit_value = 4'(ch - dtts_pkg::CHAR_ZERO);
  assign item_stall  = queue_full;
  assign push        = item_valid && !queue_full;

  always_comb begin
    push_op.last  = item.last_char;
    push_op.digit = digit_value;
    push_op.mult  = '0;
    push_op.kind  = dtts_pkg::OP_BAD;
    if (ch >= dtts_pkg::CHAR_ZERO && ch <= dtts_pkg::CHAR_NINE) begin
      push_op.kind = dtts_pkg::OP_DIGIT;
    end else begin
      unique case (ch)
        dtts_pkg::CHAR_DAY: begin
          push_op.kind = dtts_pkg::OP_UNIT;
          push_op.mult = dtts_pkg::SECS_PER_DAY;
        end
        dtts_pkg::CHAR_HOUR: begin
          push_op.kind = dtts_pkg::OP_UNIT;
          push_op.mult = dtts_pkg::SECS_PER_HOUR;
        end
        dtts_pkg::CHAR_MIN: begin
          push_op.kind = dtts_pkg::OP_UNIT;
          push_op.mult = dtts_pkg::SECS_PER_MIN;
        end
        dtts_pkg::CHAR_SEC: begin
          push_op.kind = dtts_pkg::OP_UNIT;
          push_op.mult = dtts_pkg::SECS_PER_SEC;
        end
        default: begin
          push_op.kind = dtts_pkg::OP_BAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/dtts_queue.sv */
// ----------------------------------------------------------------------------
// dtts_queue
// Short first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
`default_nettype none

module dtts_queue #(
  parameter int DEPTH = 4
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  dtts_pkg::op_t push_op,
  output logic          full,
  input  wire           pop,
  output logic          head_valid,
  output dtts_pkg::op_t head_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dtts_pkg::op_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/dtts_back.sv */
// ----------------------------------------------------------------------------
// dtts_back
// Executes queued operations on the running number and total, and holds the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtts_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               head_valid,
  input  dtts_pkg::op_t     head_op,
  output logic              pop,
  output logic              result_valid,
  input  wire               result_stall,
  output dtts_pkg::out_item_t result
);

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] total;
  logic [31:0] total_next;
  logic        err;
  logic        err_next;
  logic        out_free;
  logic        load;
  logic [31:0] product;

  assign out_free = !result_valid || !result_stall;
  assign pop      = head_valid && (!head_op.last || out_free);
  assign load     = pop && head_op.last;
  // Only the low 32 bits of the product matter since the total wraps.
  assign product  = acc * 32'(head_op.mult);

  always_comb begin
    acc_next   = acc;
    total_next = total;
    err_next   = err;
    if (!err) begin
      unique case (head_op.kind)
        dtts_pkg::OP_DIGIT: begin
          acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + 32'(head_op.digit);
        end
        dtts_pkg::OP_UNIT: begin
          total_next = total + product;
          acc_next   = '0;
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      total        <= '0;
      err          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (head_op.last) begin
          acc   <= '0;
          total <= '0;
          err   <= 1'b0;
        end else begin
          acc   <= acc_next;
          total <= total_next;
          err   <= err_next;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.total_seconds <= err_next ? 32'd0 : total_next;
      result.bad_format    <= err_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/duration_text_to_seconds.sv */
// ----------------------------------------------------------------------------
// duration_text_to_seconds
// Converts a duration text such as 1d2h30m, one character per item, into a
// count of seconds.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (item_valid, item_stall, item) carries one character of
// the text per item, with last_char set on the final character. The output
// channel (result_valid, result_stall, result) carries one item per text:
// the total in seconds and a bad-format flag, with the total forced to zero
// when any character other than a digit or one of the unit letters d, h, m,
// s appeared. Digits with no unit after them at the end are dropped, and all
// arithmetic wraps modulo 2^32.
// Throughput is one character per cycle while item_stall is low. Results
// go through the queue to the output register; the back end updates the
// running number or total with one constant multiply and one add per cycle.
// A queue of QUEUE_DEPTH entries sits between the classifying front end and
// the arithmetic back end. When the receiver stalls, the result is held in
// the output register, characters of the next text keep flowing into the
// back end, and only the next last character waits; item_stall rises once
// the queue is full. Reset clears the queue, the running state and the
// output valid; the block takes items as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module duration_text_to_seconds #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  dtts_pkg::in_item_t  item,
  output logic                result_valid,
  input  wire                 result_stall,
  output dtts_pkg::out_item_t result
);

  // Front end to queue.
  logic          push;
  dtts_pkg::op_t push_op;
  logic          queue_full;

  // Queue to back end.
  logic          pop;
  logic          head_valid;
  dtts_pkg::op_t head_op;

  // Classifies each accepted character and pushes it when there is room.
  dtts_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  // Decouples acceptance from execution so each side stalls on its own.
  dtts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Runs the digit and unit arithmetic and presents the result.
  dtts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

/* dv/duration_text_to_seconds_test.sv */
// ----------------------------------------------------------------------------
// duration_text_to_seconds_test
// Self-checking testbench for the duration text to seconds converter.
// Duration texts are fed one character per item. Each accepted character
// also goes into a local model of the parser, and that model queues the
// expected duration whenever a last character goes in. The output side
// compares every result it takes with the oldest expected duration.
// ----------------------------------------------------------------------------
`default_nettype none

module duration_text_to_seconds_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;

  // All inputs of the block start at known values.
  logic                item_valid = 1'b0;
  logic                item_stall;
  dtts_pkg::in_item_t  item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  dtts_pkg::out_item_t result;

  duration_text_to_seconds dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Characters waiting to be sent, and durations waiting to come back.
  dtts_pkg::in_item_t  pending_chars[$];
  dtts_pkg::out_item_t expected_durations[$];

  // Chance, in percent, that the sender idles or the receiver stalls in a cycle.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned error_count   = 0;
  int unsigned chars_queued  = 0;

  // Local copy of the parser state.
  logic [31:0] number_so_far = '0;
  logic [31:0] seconds_so_far = '0;
  logic        text_is_bad = 1'b0;

  char_t unit_chars[4] = '{dtts_pkg::CHAR_DAY, dtts_pkg::CHAR_HOUR,
                           dtts_pkg::CHAR_MIN, dtts_pkg::CHAR_SEC};

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Feeds one accepted character into the local parser. Once a bad character
  // has shown up, the rest of the text is ignored until its last character,
  // where the expected duration is queued and the state cleared.
  task automatic parse_char(input dtts_pkg::in_item_t it);
    logic [31:0] unit_secs;
    if (!text_is_bad) begin
      if (it.char_code >= dtts_pkg::CHAR_ZERO && it.char_code <= dtts_pkg::CHAR_NINE) begin
        number_so_far = number_so_far * 32'd10
                        + {24'd0, it.char_code - dtts_pkg::CHAR_ZERO};
      end else begin
        unit_secs = '0;
        case (it.char_code)
          dtts_pkg::CHAR_DAY:  unit_secs = 32'(dtts_pkg::SECS_PER_DAY);
          dtts_pkg::CHAR_HOUR: unit_secs = 32'(dtts_pkg::SECS_PER_HOUR);
          dtts_pkg::CHAR_MIN:  unit_secs = 32'(dtts_pkg::SECS_PER_MIN);
          dtts_pkg::CHAR_SEC:  unit_secs = 32'(dtts_pkg::SECS_PER_SEC);
          default:             text_is_bad = 1'b1;
        endcase
        if (!text_is_bad) begin
          seconds_so_far = seconds_so_far + number_so_far * unit_secs;
          number_so_far  = '0;
        end
      end
    end
    if (it.last_char) begin
      // Digits still waiting for a unit are simply dropped here.
      expected_durations.insert(expected_durations.size(),
          dtts_pkg::out_item_t'{total_seconds: text_is_bad ? 32'd0 : seconds_so_far,
                                bad_format:    text_is_bad});
      number_so_far  = '0;
      seconds_so_far = '0;
      text_is_bad    = 1'b0;
    end
  endtask

  // Sender. A character stays on the bus until it is taken; after that the
  // next one goes out at once unless the sender decides to idle this cycle.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        parse_char(item);
      end
      if (!item_valid || !item_stall) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item       <= pending_chars.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stalls at random and checks every duration it takes.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
      if (result_valid && !result_stall) begin
        if (expected_durations.size() == 0) begin
          report_mismatch($sformatf("unexpected result total=%0d bad=%0b",
                                    result.total_seconds, result.bad_format));
        end else begin
          dtts_pkg::out_item_t want;
          want = expected_durations.pop_front();
          if (result.total_seconds !== want.total_seconds) begin
            report_mismatch($sformatf("total_seconds got %0d, want %0d",
                                      result.total_seconds, want.total_seconds));
          end
          if (result.bad_format !== want.bad_format) begin
            report_mismatch($sformatf("bad_format got %0b, want %0b",
                                      result.bad_format, want.bad_format));
          end
        end
      end
    end
  end

  // Queues a whole text; only its final character carries the last flag.
  task automatic queue_chars(input char_t txt[$]);
    for (int i = 0; i < txt.size(); i++) begin
      pending_chars.insert(pending_chars.size(),
          dtts_pkg::in_item_t'{char_code: txt[i], last_char: (i == txt.size() - 1)});
    end
    chars_queued += txt.size();
  endtask

  task automatic queue_string(input string s);
    char_t txt[$];
    for (int i = 0; i < s.len(); i++) begin
      txt.insert(txt.size(), s[i]);
    end
    queue_chars(txt);
  endtask

  task automatic queue_single(input char_t c);
    char_t txt[$];
    txt.insert(txt.size(), c);
    queue_chars(txt);
  endtask

  // Mostly well-formed texts with random numbers and units, some with one
  // stray byte dropped in, and a few made only of random bytes. Now and then
  // a term gets a long digit run so that the arithmetic wraps.
  task automatic queue_random_text();
    char_t       txt[$];
    int unsigned style;
    int unsigned terms;
    int unsigned ndigits;
    int unsigned len;
    style = $urandom_range(99);
    if (style < 90) begin
      terms = $urandom_range(1, 4);
      for (int t = 0; t < terms; t++) begin
        ndigits = ($urandom_range(9) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 3);
        for (int d = 0; d < ndigits; d++) begin
          txt.insert(txt.size(), dtts_pkg::CHAR_ZERO + char_t'($urandom_range(9)));
        end
        txt.insert(txt.size(), unit_chars[$urandom_range(3)]);
      end
      // Some texts end in digits that never get a unit.
      if ($urandom_range(99) < 15) begin
        ndigits = $urandom_range(1, 2);
        for (int d = 0; d < ndigits; d++) begin
          txt.insert(txt.size(), dtts_pkg::CHAR_ZERO + char_t'($urandom_range(9)));
        end
      end
      if (style >= 75) begin
        txt.insert($urandom_range(txt.size()), char_t'($urandom_range(255)));
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        txt.insert(txt.size(), char_t'($urandom_range(255)));
      end
    end
    queue_chars(txt);
  endtask

  // Waits until every queued character has been taken by the block.
  task automatic wait_chars_sent();
    while (pending_chars.size() != 0 || item_valid) @(negedge clk);
  endtask

  // Waits until every expected duration has come back.
  task automatic wait_results_in();
    while (expected_durations.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // First phase: sender idles a quarter of the time, receiver stalls often.
    send_idle_pct = 25;
    stall_pct     = 61;

    // Directed texts: a plain mixed duration, a unit with no digits, digits
    // with no unit, a bad character followed by characters that must be
    // ignored, the lowest and highest byte values, a wrapping day count and
    // a plain seconds value.
    queue_string("1d2h30m");
    queue_string("h");
    queue_string("25");
    queue_string("9x3s");
    queue_single(8'hFF);
    queue_single(8'h00);
    queue_string("50000d");
    queue_string("7s");

    while (chars_queued < 340) queue_random_text();
    wait_chars_sent();

    // Hold the sender back until everything sent so far has come out.
    wait_results_in();

    // Second phase: the idle rates swap sides.
    send_idle_pct = 61;
    stall_pct     = 25;
    while (chars_queued < 660) queue_random_text();
    wait_chars_sent();

    // Last phase: full rate on both sides.
    send_idle_pct = 0;
    stall_pct     = 0;
    while (chars_queued < 975) queue_random_text();
    wait_chars_sent();
    wait_results_in();

    // Catch any stray result before the final report.
    repeat (10) @(negedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400us;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
